[sv/psu_pkg.sv]
// psu_pkg: shared types, codes and helper functions of the png scanline unfilter
// used by psu_cfg, psu_front, psu_recon and png_scanline_unfilter_core
// no dependencies

package psu_pkg;

  // default for the widest supported row, in pixels
  localparam int MAX_WIDTH_DEFAULT = 2048;

  // configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_ROW_WIDTH = 2'd0;
  localparam logic [1:0] REG_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_HAS_ALPHA = 2'd2;

  localparam logic [11:0] ROW_WIDTH_RESET = 12'd1;
  localparam logic [15:0] HEIGHT_RESET    = 16'd1;

  // filter type codes as they appear in the stream
  localparam logic [7:0] FILT_CODE_SUB   = 8'd1;
  localparam logic [7:0] FILT_CODE_UP    = 8'd2;
  localparam logic [7:0] FILT_CODE_AVG   = 8'd3;
  localparam logic [7:0] FILT_CODE_PAETH = 8'd4;

  // storage slots, bgra order
  localparam logic [1:0] SLOT_BLUE  = 2'd0;
  localparam logic [1:0] SLOT_GREEN = 2'd1;
  localparam logic [1:0] SLOT_RED   = 2'd2;
  localparam logic [1:0] SLOT_ALPHA = 2'd3;

  localparam logic [15:0] ROW_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    FILT_NONE,
    FILT_SUB,
    FILT_UP,
    FILT_AVG,
    FILT_PAETH
  } psu_filt_e;

  typedef struct packed {
    logic [11:0] row_width;
    logic [15:0] height;
    logic        has_alpha;
  } psu_cfg_t;

  // one data byte on its way from the front stage to reconstruction
  typedef struct packed {
    logic [7:0]  val;
    logic [10:0] column;
    logic [15:0] row;
    logic [1:0]  slot;
    logic        stored;
    logic        col_nz;
    logic        row_nz;
    psu_filt_e   filt;
    logic        ovf;
    logic        clr;     // first data byte of a new image, neighbor registers start at zero
  } psu_item_t;

  function automatic psu_filt_e filt_decode(input logic [7:0] code);
    psu_filt_e f;
    unique case (code)
      FILT_CODE_SUB:   f = FILT_SUB;
      FILT_CODE_UP:    f = FILT_UP;
      FILT_CODE_AVG:   f = FILT_AVG;
      FILT_CODE_PAETH: f = FILT_PAETH;
      default:         f = FILT_NONE;
    endcase
    return f;
  endfunction

  // stream channel order rgba to storage slot
  function automatic logic [1:0] slot_of(input logic [1:0] ch);
    logic [1:0] s;
    unique case (ch)
      2'd0:    s = SLOT_RED;
      2'd1:    s = SLOT_GREEN;
      2'd2:    s = SLOT_BLUE;
      default: s = SLOT_ALPHA;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] paeth_pred(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    logic signed [10:0] p;
    logic signed [10:0] pa;
    logic signed [10:0] pb;
    logic signed [10:0] pc;
    logic [7:0]         r;
    p  = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({3'b000, c});
    pa = p - $signed({3'b000, a});
    pb = p - $signed({3'b000, b});
    pc = p - $signed({3'b000, c});
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    if (pc < 0) pc = -pc;
    if (pa <= pb && pa <= pc) r = a;
    else if (pb <= pc) r = b;
    else r = c;
    return r;
  endfunction

endpackage

[sv/psu_cfg.sv]
// psu_cfg: apb-style configuration registers of the scanline unfilter
// depends on psu_pkg

module psu_cfg import psu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output psu_cfg_t           cfg_o
);

  logic [11:0] row_width_q, row_width_d;
  logic [15:0] height_q, height_d;
  logic        has_alpha_q, has_alpha_d;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    row_width_d = row_width_q;
    height_d    = height_q;
    has_alpha_d = has_alpha_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_ROW_WIDTH: row_width_d = pwdata[11:0];
        REG_HEIGHT:    height_d    = pwdata[15:0];
        REG_HAS_ALPHA: has_alpha_d = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= ROW_WIDTH_RESET;
      height_q    <= HEIGHT_RESET;
      has_alpha_q <= 1'b0;
    end else begin
      row_width_q <= row_width_d;
      height_q    <= height_d;
      has_alpha_q <= has_alpha_d;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ROW_WIDTH: prdata = {20'd0, row_width_q};
      REG_HEIGHT:    prdata = {16'd0, height_q};
      REG_HAS_ALPHA: prdata = {31'd0, has_alpha_q};
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = '{row_width: row_width_q, height: height_q, has_alpha: has_alpha_q};

endmodule

[sv/psu_front.sv]
// psu_front: position tracking, filter byte capture and item register of the unfilter
// depends on psu_pkg

module psu_front import psu_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT,
  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int WCW = $clog2(MAX_WIDTH + 1),
  localparam int AW  = $clog2(MAX_WIDTH * 4)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  psu_cfg_t      cfg_i,
  input  logic          accept_i,
  input  logic          move_i,
  input  logic          image_start_i,
  input  logic [7:0]    data_byte_i,
  output logic          rd_en_o,
  output logic [AW-1:0] rd_addr_o,
  output logic          item_valid_o,
  output psu_item_t     item_o
);

  logic [CW-1:0]  col_q, col_d, cur_col;
  logic [15:0]    row_q, row_d, cur_row;
  logic [1:0]     ch_q, ch_d, cur_ch;
  psu_filt_e      filt_q, filt_d, cur_filt;
  logic           await_q, await_d, cur_await;
  logic           ovf_q, ovf_d, cur_ovf;
  logic           clr_q;
  logic           item_valid_q;
  psu_item_t      item_q, item_d;

  logic           is_filter;
  logic           stored;
  logic [1:0]     slot;
  logic [2:0]     bpp;
  logic [WCW-1:0] width_eff;
  logic           last_ch;
  logic           last_col;

  always_comb begin
    // image start clears position before the byte is looked at
    cur_col   = image_start_i ? '0 : col_q;
    cur_row   = image_start_i ? '0 : row_q;
    cur_ch    = image_start_i ? '0 : ch_q;
    cur_filt  = image_start_i ? FILT_NONE : filt_q;
    cur_await = image_start_i ? 1'b1 : await_q;
    cur_ovf   = image_start_i ? 1'b0 : ovf_q;

    is_filter = (cur_col == '0) && (cur_ch == 2'd0) && cur_await;
    slot      = slot_of(cur_ch);
    stored    = cur_row < cfg_i.height;
    bpp       = cfg_i.has_alpha ? 3'd4 : 3'd3;

    if (cfg_i.row_width == 12'd0) width_eff = WCW'(1);
    else if (32'(cfg_i.row_width) > MAX_WIDTH) width_eff = WCW'(MAX_WIDTH);
    else width_eff = WCW'(cfg_i.row_width);

    last_ch  = ({1'b0, cur_ch} + 3'd1) >= bpp;
    last_col = (WCW'(cur_col) + WCW'(1)) >= width_eff;

    col_d   = cur_col;
    row_d   = cur_row;
    ch_d    = cur_ch;
    filt_d  = cur_filt;
    await_d = cur_await;
    ovf_d   = cur_ovf;

    if (is_filter) begin
      filt_d  = filt_decode(data_byte_i);
      await_d = 1'b0;
    end else begin
      await_d = 1'b1;
      ovf_d   = cur_ovf | ~stored;
      if (last_ch) begin
        ch_d = 2'd0;
        if (last_col) begin
          col_d = '0;
          if (cur_row != ROW_MAX) row_d = cur_row + 16'd1;
        end else begin
          col_d = cur_col + CW'(1);
        end
      end else begin
        ch_d = cur_ch + 2'd1;
      end
    end

    item_d = '{
      val:    data_byte_i,
      column: 11'(cur_col),
      row:    cur_row,
      slot:   slot,
      stored: stored,
      col_nz: cur_col != '0,
      row_nz: cur_row != 16'd0,
      filt:   cur_filt,
      ovf:    cur_ovf | ~stored,
      clr:    clr_q
    };
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      row_q        <= '0;
      ch_q         <= '0;
      filt_q       <= FILT_NONE;
      await_q      <= 1'b1;
      ovf_q        <= 1'b0;
      clr_q        <= 1'b0;
      item_valid_q <= 1'b0;
    end else begin
      if (accept_i) begin
        col_q   <= col_d;
        row_q   <= row_d;
        ch_q    <= ch_d;
        filt_q  <= filt_d;
        await_q <= await_d;
        ovf_q   <= ovf_d;
        // an image start byte is always a filter byte, so this marks the next data byte
        clr_q   <= image_start_i;
      end
      if (accept_i) item_valid_q <= ~is_filter;
      else if (move_i) item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && !is_filter) item_q <= item_d;
  end

  assign rd_en_o      = accept_i && !is_filter;
  assign rd_addr_o    = AW'({cur_col, slot});
  assign item_valid_o = item_valid_q;
  assign item_o       = item_q;

  // a filter byte never turns into a result
  a_filter_no_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && is_filter |=> !item_valid_q)
    else $error("filter byte produced an item");

  // rows only move forward inside one image
  a_row_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !image_start_i |=> row_q >= $past(row_q))
    else $error("row went backwards without image start");

  // a waiting item is held until it moves on
  a_item_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_q && !move_i && !accept_i |=> item_valid_q && $stable(item_q))
    else $error("waiting item lost or changed");

endmodule

[sv/psu_recon.sv]
// psu_recon: prior row memory, neighbor registers, filter reconstruction and output register
// depends on psu_pkg

module psu_recon import psu_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT,
  localparam int AW = $clog2(MAX_WIDTH * 4)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic          item_valid_i,
  input  psu_item_t     item_i,
  input  logic          out_stall_i,
  output logic          move_o,
  output logic          out_free_o,
  output logic          out_valid_o,
  output logic [7:0]    pixel_value_o,
  output logic [10:0]   out_column_o,
  output logic [15:0]   out_row_o,
  output logic [1:0]    out_channel_o,
  output logic          overflow_o
);

  logic [7:0]    line_mem [MAX_WIDTH*4];
  logic [7:0]    rd_data_q;
  logic [AW-1:0] wr_addr_q;
  logic [7:0]    left_q [4];
  logic [7:0]    ul_q [4];

  logic          out_valid_q;
  logic [7:0]    pixel_q;
  logic [10:0]   column_q;
  logic [15:0]   row_q;
  logic [1:0]    slot_q;
  logic          ovf_q;

  logic [7:0]    a, b, c;
  logic [8:0]    ab_sum;
  logic [7:0]    pred;
  logic [7:0]    res;
  logic          move;
  logic          out_free;

  assign out_free = !out_valid_q || !out_stall_i;
  assign move     = item_valid_i && out_free;

  // prior row memory, registered read issued when the byte is taken
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= line_mem[rd_addr_i];
      wr_addr_q <= rd_addr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move && item_i.stored) line_mem[wr_addr_q] <= res;
  end

  always_comb begin
    a      = item_i.col_nz ? left_q[item_i.slot] : 8'd0;
    b      = item_i.row_nz ? rd_data_q : 8'd0;
    c      = (item_i.col_nz && item_i.row_nz) ? ul_q[item_i.slot] : 8'd0;
    ab_sum = {1'b0, a} + {1'b0, b};
    case (item_i.filt)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = ab_sum[8:1];
      FILT_PAETH: pred = paeth_pred(a, b, c);
      default:    pred = 8'd0;
    endcase
    res = item_i.val + pred;
  end

  // neighbor registers; the first data byte of an image zeroes the slots it does not write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '{default: 8'd0};
      ul_q   <= '{default: 8'd0};
    end else if (move) begin
      for (int k = 0; k < 4; k++) begin
        if (item_i.stored && item_i.slot == 2'(k)) begin
          left_q[k] <= res;
          ul_q[k]   <= b;
        end else if (item_i.clr) begin
          left_q[k] <= 8'd0;
          ul_q[k]   <= 8'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (move) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      pixel_q  <= item_i.stored ? res : 8'd0;
      column_q <= item_i.column;
      row_q    <= item_i.row;
      slot_q   <= item_i.slot;
      ovf_q    <= item_i.ovf;
    end
  end

  assign move_o        = move;
  assign out_free_o    = out_free;
  assign out_valid_o   = out_valid_q;
  assign pixel_value_o = pixel_q;
  assign out_column_o  = column_q;
  assign out_row_o     = row_q;
  assign out_channel_o = slot_q;
  assign overflow_o    = ovf_q;

  // never overwrite a result the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move |-> !(out_valid_q && out_stall_i))
    else $error("output register overwritten while stalled");

  // left neighbor tracks the value just reconstructed
  a_left_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move && item_i.stored |=> left_q[$past(item_i.slot)] == $past(res))
    else $error("left neighbor not updated");

  // a taken result with nothing behind it empties the output
  a_out_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_stall_i && !move |=> !out_valid_q)
    else $error("stale result shown twice");

endmodule

[sv/png_scanline_unfilter_core.sv]
// png_scanline_unfilter_core: top level of the png scanline unfilter
// depends on psu_pkg, psu_cfg, psu_front and psu_recon

// usage
// input channel: in_valid_i / in_stall_o with image_start_i and data_byte_i, one
//   inflated byte per transaction; a transaction happens when valid is high and
//   stall is low at a rising edge
// the first byte of each row is the filter type and yields no result; every other
//   byte yields one result transaction with pixel_value_o, out_column_o, out_row_o,
//   out_channel_o (bgra slot) and the sticky overflow_o
// output channel: out_valid_o / out_stall_i, same rules as the input
// path: a taken byte is registered in the item register, then in the output register
// throughput: one byte per cycle while the output is not stalled, set by the single
//   prior-row memory port pair (one read at intake, one write when the byte moves on)
// when the receiver stalls, the held result stays and one more byte may sit in the
//   item register; after that in_stall_o rises until the output drains
// reset: registers return to width 1, height 1, rgb; position, filter and overflow
//   state are cleared; the prior-row memory is not cleared (row 0 ignores what it reads)
// configuration: apb-style writes at 4*index, to be issued only while the block is idle

module png_scanline_unfilter_core import psu_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  // input byte stream
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               image_start_i,
  input  logic [7:0]         data_byte_i,
  // reconstructed bytes
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         pixel_value_o,
  output logic [10:0]        out_column_o,
  output logic [15:0]        out_row_o,
  output logic [1:0]         out_channel_o,
  output logic               overflow_o
);

  localparam int AW = $clog2(MAX_WIDTH * 4);

  psu_cfg_t      cfg;
  psu_item_t     item;
  logic          item_valid;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          move;
  logic          out_free;
  logic          accept;

  // the item register can take a new byte when empty or when its byte moves on
  assign in_stall_o = item_valid && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  psu_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // stage one: position counters, filter capture, memory read issue
  psu_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .accept_i      (accept),
    .move_i        (move),
    .image_start_i (image_start_i),
    .data_byte_i   (data_byte_i),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .item_valid_o  (item_valid),
    .item_o        (item)
  );

  // stage two: predictor, prior-row write back, output register
  psu_recon #(.MAX_WIDTH(MAX_WIDTH)) u_recon (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rd_en_i       (rd_en),
    .rd_addr_i     (rd_addr),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .out_stall_i   (out_stall_i),
    .move_o        (move),
    .out_free_o    (out_free),
    .out_valid_o   (out_valid_o),
    .pixel_value_o (pixel_value_o),
    .out_column_o  (out_column_o),
    .out_row_o     (out_row_o),
    .out_channel_o (out_channel_o),
    .overflow_o    (overflow_o)
  );

endmodule
